// ===== rtl/nat_rule_table_assert.svh =====
// ----------------------------------------------------------------------------
// nat rule table assertion macros
// concurrent checks compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef NAT_RULE_TABLE_ASSERT_SVH
`define NAT_RULE_TABLE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define NRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define NRT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NRT_ASSERT_IMP(label, ante, cons, msg)
`define NRT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/nrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nrt_pkg
// types, command and status codes shared by the nat rule table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrt_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_APPLY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // rule kinds
    localparam logic KIND_SNAT = 1'b0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        rule_kind;
        logic [31:0] match_ip;
        logic [15:0] match_port;
        logic [31:0] new_ip;
        logic [15:0] new_port;
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [31:0] dst_ip;
        logic [15:0] dport;
    } nrt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_src_ip;
        logic [15:0] out_src_port;
        logic [31:0] out_dst_ip;
        logic [15:0] out_dst_port;
    } nrt_rsp_t;

    // one stored rule
    typedef struct packed {
        logic        kind;
        logic [31:0] match_ip;
        logic [15:0] match_port;
        logic [31:0] new_ip;
        logic [15:0] new_port;
    } nrt_entry_t;

    // compare unit verdict and rewritten packet
    typedef struct packed {
        logic        hit;
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [31:0] dst_ip;
        logic [15:0] dport;
    } nrt_match_t;

    localparam int ENTRY_W = $bits(nrt_entry_t);

    // response that echoes the packet of a transaction unchanged
    function automatic nrt_rsp_t echo_rsp(input nrt_req_t r, input logic [1:0] st);
        nrt_rsp_t o;
        o.status       = st;
        o.out_src_ip   = r.src_ip;
        o.out_src_port = r.sport;
        o.out_dst_ip   = r.dst_ip;
        o.out_dst_port = r.dport;
        return o;
    endfunction

endpackage

// ===== rtl/nrt_ram.sv =====
// ----------------------------------------------------------------------------
// nrt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nrt_match.sv =====
// ----------------------------------------------------------------------------
// nrt_match
// shared compare unit: tests one stored rule against the current transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrt_match (
    input  nrt_pkg::nrt_entry_t entry,
    input  nrt_pkg::nrt_req_t   req,
    output nrt_pkg::nrt_match_t res
);

    logic ip_hit;
    logic port_hit;
    logic [31:0] side_ip;
    logic [15:0] side_port;
    logic [31:0] rw_ip;
    logic [15:0] rw_port;
    logic snat;

    assign snat      = (entry.kind == nrt_pkg::KIND_SNAT);
    // remove looks at the rule pair only; apply looks at one packet side
    assign side_ip   = (req.cmd == nrt_pkg::CMD_APPLY) ? (snat ? req.src_ip : req.dst_ip)
                                                       : req.match_ip;
    assign side_port = (req.cmd == nrt_pkg::CMD_APPLY) ? (snat ? req.sport : req.dport)
                                                       : req.match_port;

    // zero match value is a wildcard on apply only
    assign ip_hit   = (entry.match_ip == side_ip) ||
                      ((req.cmd == nrt_pkg::CMD_APPLY) && (entry.match_ip == 32'd0));
    assign port_hit = (entry.match_port == side_port) ||
                      ((req.cmd == nrt_pkg::CMD_APPLY) && (entry.match_port == 16'd0));

    // zero new value keeps the original
    assign rw_ip   = (entry.new_ip != 32'd0) ? entry.new_ip : side_ip;
    assign rw_port = (entry.new_port != 16'd0) ? entry.new_port : side_port;

    always_comb
    begin
        res.hit    = ip_hit && port_hit;
        res.src_ip = req.src_ip;
        res.sport  = req.sport;
        res.dst_ip = req.dst_ip;
        res.dport  = req.dport;
        if (snat)
        begin
            res.src_ip = rw_ip;
            res.sport  = rw_port;
        end
        else
        begin
            res.dst_ip = rw_ip;
            res.dport  = rw_port;
        end
    end

endmodule

// ===== rtl/nat_rule_table.sv =====
// ----------------------------------------------------------------------------
// nat_rule_table
// ordered static nat rule table with first-match translation
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and gives one
// response on rsp, marked by done for exactly one cycle; the receiver cannot
// stall it, so capture rsp whenever done is high. Add and any unused command
// answer in the cycle after acceptance. Apply reads the rules from a single
// ram read port, one rule per cycle, and answers once the first matching rule
// has been compared, or after the last rule on a miss. Remove scans the
// same way up to the equal pair, then moves each later rule down one place,
// again one rule per cycle through that port. busy is high during the scan
// and the move; a new transaction may start in the cycle that done is shown.
// The rule store needs no clearing after reset: only entries below the rule
// count are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nat_rule_table #(
    parameter int MAX_RULES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  nrt_pkg::nrt_req_t req,
    output logic             done,
    output nrt_pkg::nrt_rsp_t rsp
);

`include "nat_rule_table_assert.svh"

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int SUM_W = CNT_W + 1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    nrt_pkg::nrt_req_t   item_reg, item_next;
    nrt_pkg::nrt_rsp_t   rsp_reg, rsp_next;
    logic                done_reg, done_next;

    // rule memory ports
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [nrt_pkg::ENTRY_W-1:0]  wr_data;
    logic [IDX_W-1:0]             rd_addr;
    logic [nrt_pkg::ENTRY_W-1:0]  rd_data;

    nrt_pkg::nrt_entry_t new_entry;
    nrt_pkg::nrt_match_t cmp;

    logic             accept;
    logic [SUM_W-1:0] nxt1;      // index of the rule after the current one
    logic [SUM_W-1:0] nxt2;      // two past the current one, for the move
    logic [SUM_W-1:0] cnt_ext;

    assign accept  = start && !busy;
    assign nxt1    = SUM_W'(idx_reg) + SUM_W'(1);
    assign nxt2    = SUM_W'(idx_reg) + SUM_W'(2);
    assign cnt_ext = SUM_W'(count_reg);

    assign new_entry.kind       = req.rule_kind;
    assign new_entry.match_ip   = req.match_ip;
    assign new_entry.match_port = req.match_port;
    assign new_entry.new_ip     = req.new_ip;
    assign new_entry.new_port   = req.new_port;

    nrt_ram #(
        .WIDTH (nrt_pkg::ENTRY_W),
        .DEPTH (MAX_RULES),
        .AW    (IDX_W)
    ) u_rules (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared compare unit sees the rule that the ram returned this cycle
    nrt_match u_match (
        .entry (nrt_pkg::nrt_entry_t'(rd_data)),
        .req   (item_reg),
        .res   (cmp)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        item_next  = item_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // rule 0 is always being read so a scan starts with data ready
                rd_addr = '0;
                if (accept)
                begin
                    item_next = req;
                    idx_next  = '0;
                    case (req.cmd)
                        nrt_pkg::CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CNT_W'(MAX_RULES))
                            begin
                                rsp_next = nrt_pkg::echo_rsp(req, nrt_pkg::ST_FULL);
                            end
                            else
                            begin
                                // append at the end of the table
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = new_entry;
                                count_next = count_reg + CNT_W'(1);
                                rsp_next   = nrt_pkg::echo_rsp(req, nrt_pkg::ST_OK);
                            end
                        end
                        nrt_pkg::CMD_REMOVE, nrt_pkg::CMD_APPLY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = nrt_pkg::echo_rsp(req, nrt_pkg::ST_NO_MATCH);
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused command code: nothing changes
                            done_next = 1'b1;
                            rsp_next  = nrt_pkg::echo_rsp(req, nrt_pkg::ST_NO_MATCH);
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // keep the read one rule ahead of the compare
                if (nxt1 < cnt_ext)
                begin
                    rd_addr = nxt1[IDX_W-1:0];
                end
                if (cmp.hit)
                begin
                    if (item_reg.cmd == nrt_pkg::CMD_APPLY)
                    begin
                        state_next            = ST_IDLE;
                        done_next             = 1'b1;
                        rsp_next.status       = nrt_pkg::ST_OK;
                        rsp_next.out_src_ip   = cmp.src_ip;
                        rsp_next.out_src_port = cmp.sport;
                        rsp_next.out_dst_ip   = cmp.dst_ip;
                        rsp_next.out_dst_port = cmp.dport;
                    end
                    else if (nxt1 < cnt_ext)
                    begin
                        // later rules must move down over the removed one
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        // removed rule was the last one
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        rsp_next   = nrt_pkg::echo_rsp(item_reg, nrt_pkg::ST_OK);
                    end
                end
                else if (nxt1 >= cnt_ext)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = nrt_pkg::echo_rsp(item_reg, nrt_pkg::ST_NO_MATCH);
                end
                else
                begin
                    idx_next = nxt1[IDX_W-1:0];
                end
            end

            ST_SHIFT:
            begin
                // rd_data holds rule idx+1; it moves into slot idx
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (nxt2 < cnt_ext)
                begin
                    rd_addr  = nxt2[IDX_W-1:0];
                    idx_next = nxt1[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    rsp_next   = nrt_pkg::echo_rsp(item_reg, nrt_pkg::ST_OK);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // transaction and response payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // an add that fits answers ok next cycle and grows the table by one
    `NRT_ASSERT_NXT(a_add_grows, accept && (req.cmd == nrt_pkg::CMD_ADD) && (count_reg < CNT_W'(MAX_RULES)), done && (rsp.status == nrt_pkg::ST_OK) && (count_reg == $past(count_reg) + CNT_W'(1)), "add did not append a rule")

    // a full refusal only when the table is really full
    `NRT_ASSERT_IMP(a_full_ok, done && (rsp.status == nrt_pkg::ST_FULL), count_reg == CNT_W'(MAX_RULES), "table full reported with room left")

    // the move never writes at or beyond the last live rule
    `NRT_ASSERT_IMP(a_shift_range, state_reg == ST_SHIFT, (SUM_W'(idx_reg) + SUM_W'(1)) < SUM_W'(count_reg), "rule move out of range")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for nat_rule_table: a clocked driver feeds add, remove,
// apply and unused-command transactions from a pending queue with random idle
// bursts, and a clocked monitor predicts each accepted transaction with its
// own rule table and checks every response, field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int          TABLE_DEPTH = 16;
    localparam int          RAND_ITEMS  = 636;
    localparam int          CALM_TAIL   = 100;     // last random items sent back to back
    localparam int          SEG_LEN     = 60;      // random items per traffic mix
    localparam int          SETTLE      = 40;      // quiet cycles after the last response
    localparam int          LIMIT       = 200000;  // cycle budget for the whole run
    localparam int          MAX_REPORTS = 10;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic        KIND_DNAT   = 1'b1;

    // one transaction waiting for the driver
    typedef struct {
        nrt_pkg::nrt_req_t req;
        bit                drain;      // hold off until every response is back
        bit                may_idle;   // idle bursts allowed in front of it
    } pend_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    nrt_pkg::nrt_req_t req = '0;
    logic              done;
    nrt_pkg::nrt_rsp_t rsp;

    pend_t             cmd_q[$];
    pend_t             drv_item;
    nrt_pkg::nrt_rsp_t due_rsp_q[$];
    nrt_pkg::nrt_rsp_t want;
    logic [47:0]       used_pairs[$];     // match pairs handed to add, for hits later
    logic [31:0]       ip_pool[8];
    logic [15:0]       port_pool[8];

    // predicted rule table
    nrt_pkg::nrt_entry_t rules[TABLE_DEPTH];
    int                  rule_cnt = 0;

    int          idle_left = 0;
    int          taken_cnt = 0;
    int          answered_cnt = 0;
    int          total_items = 0;
    int          bad_cnt = 0;
    int          cycle_cnt = 0;

    nat_rule_table #(
        .MAX_RULES(TABLE_DEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // zero on the rule side is a wildcard
    function automatic bit pair_hits(input nrt_pkg::nrt_entry_t e, input logic [31:0] ip,
                                     input logic [15:0] port);
        return (e.match_ip == '0 || e.match_ip == ip) &&
               (e.match_port == '0 || e.match_port == port);
    endfunction

    // response of one transaction, updating the predicted table on the way
    function automatic nrt_pkg::nrt_rsp_t rule_table_response(input nrt_pkg::nrt_req_t r);
        nrt_pkg::nrt_rsp_t   o;
        nrt_pkg::nrt_entry_t e;
        int                  i;
        int                  j;
        bit                  found;
        o.status       = nrt_pkg::ST_NO_MATCH;
        o.out_src_ip   = r.src_ip;
        o.out_src_port = r.sport;
        o.out_dst_ip   = r.dst_ip;
        o.out_dst_port = r.dport;
        found          = 1'b0;
        case (r.cmd)
            nrt_pkg::CMD_ADD:
            begin
                if (rule_cnt >= TABLE_DEPTH)
                begin
                    o.status = nrt_pkg::ST_FULL;
                end
                else
                begin
                    e.kind       = r.rule_kind;
                    e.match_ip   = r.match_ip;
                    e.match_port = r.match_port;
                    e.new_ip     = r.new_ip;
                    e.new_port   = r.new_port;
                    rules[rule_cnt] = e;
                    rule_cnt++;
                    o.status = nrt_pkg::ST_OK;
                end
            end
            nrt_pkg::CMD_REMOVE:
            begin
                // exact pair compare, kind does not matter
                for (i = 0; i < rule_cnt; i++)
                begin
                    if (!found && rules[i].match_ip == r.match_ip &&
                        rules[i].match_port == r.match_port)
                    begin
                        found = 1'b1;
                        for (j = i; j + 1 < rule_cnt; j++)
                            rules[j] = rules[j + 1];
                    end
                end
                if (found)
                begin
                    rule_cnt--;
                    o.status = nrt_pkg::ST_OK;
                end
            end
            nrt_pkg::CMD_APPLY:
            begin
                // first hit wins, zero new value keeps the old one
                for (i = 0; i < rule_cnt; i++)
                begin
                    e = rules[i];
                    if (!found && e.kind == nrt_pkg::KIND_SNAT &&
                        pair_hits(e, o.out_src_ip, o.out_src_port))
                    begin
                        found = 1'b1;
                        if (e.new_ip != '0)
                            o.out_src_ip = e.new_ip;
                        if (e.new_port != '0)
                            o.out_src_port = e.new_port;
                    end
                    else if (!found && e.kind == KIND_DNAT &&
                             pair_hits(e, o.out_dst_ip, o.out_dst_port))
                    begin
                        found = 1'b1;
                        if (e.new_ip != '0)
                            o.out_dst_ip = e.new_ip;
                        if (e.new_port != '0)
                            o.out_dst_port = e.new_port;
                    end
                end
                if (found)
                    o.status = nrt_pkg::ST_OK;
            end
            default:
            begin
                // unused command: packet echoed, no match
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // every field random, so fields a command ignores still toggle
    function automatic nrt_pkg::nrt_req_t noise_req();
        nrt_pkg::nrt_req_t r;
        r.cmd        = 2'($urandom_range(0, 3));
        r.rule_kind  = 1'($urandom_range(0, 1));
        r.match_ip   = $urandom;
        r.match_port = 16'($urandom);
        r.new_ip     = $urandom;
        r.new_port   = 16'($urandom);
        r.src_ip     = $urandom;
        r.sport      = 16'($urandom);
        r.dst_ip     = $urandom;
        r.dport      = 16'($urandom);
        return r;
    endfunction

    function automatic nrt_pkg::nrt_req_t add_req(input logic kind, input logic [31:0] mip,
                                                  input logic [15:0] mport,
                                                  input logic [31:0] nip,
                                                  input logic [15:0] nport);
        nrt_pkg::nrt_req_t r;
        r            = noise_req();
        r.cmd        = nrt_pkg::CMD_ADD;
        r.rule_kind  = kind;
        r.match_ip   = mip;
        r.match_port = mport;
        r.new_ip     = nip;
        r.new_port   = nport;
        return r;
    endfunction

    function automatic nrt_pkg::nrt_req_t remove_req(input logic [31:0] mip,
                                                     input logic [15:0] mport);
        nrt_pkg::nrt_req_t r;
        r            = noise_req();
        r.cmd        = nrt_pkg::CMD_REMOVE;
        r.match_ip   = mip;
        r.match_port = mport;
        return r;
    endfunction

    function automatic nrt_pkg::nrt_req_t apply_req(input logic [31:0] sip,
                                                    input logic [15:0] s_pt,
                                                    input logic [31:0] dip,
                                                    input logic [15:0] d_pt);
        nrt_pkg::nrt_req_t r;
        r        = noise_req();
        r.cmd    = nrt_pkg::CMD_APPLY;
        r.src_ip = sip;
        r.sport  = s_pt;
        r.dst_ip = dip;
        r.dport  = d_pt;
        return r;
    endfunction

    // address and port pair: half the time one already used in a rule, so hits happen
    function automatic logic [47:0] pick_pair();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && used_pairs.size() > 0)
            return used_pairs[$urandom_range(0, used_pairs.size() - 1)];
        else if (sel < 8)
            return {ip_pool[$urandom_range(0, 7)], port_pool[$urandom_range(0, 7)]};
        else
            return {$urandom, 16'($urandom)};
    endfunction

    // one random transaction, add and remove weights in percent
    function automatic nrt_pkg::nrt_req_t random_req(input int add_w, input int rem_w);
        nrt_pkg::nrt_req_t r;
        logic [47:0]       m;
        logic [47:0]       s;
        logic [47:0]       d;
        int                sel;
        sel = $urandom_range(0, 99);
        m   = pick_pair();
        if (sel < add_w)
        begin
            // some wildcard sides and some keep-old new values
            if ($urandom_range(0, 9) == 0)
                m[47:16] = '0;
            if ($urandom_range(0, 9) == 0)
                m[15:0] = '0;
            used_pairs = {used_pairs, m};
            s = pick_pair();
            if ($urandom_range(0, 3) == 0)
                s[47:16] = '0;
            if ($urandom_range(0, 3) == 0)
                s[15:0] = '0;
            r = add_req(1'($urandom_range(0, 1)), m[47:16], m[15:0], s[47:16], s[15:0]);
        end
        else if (sel < add_w + rem_w)
        begin
            r = remove_req(m[47:16], m[15:0]);
        end
        else if (sel < 96)
        begin
            s = pick_pair();
            d = pick_pair();
            r = apply_req(s[47:16], s[15:0], d[47:16], d[15:0]);
        end
        else
        begin
            r     = noise_req();
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    task automatic queue_item(input nrt_pkg::nrt_req_t r, input bit drain, input bit may_idle);
        pend_t p;
        p.req      = r;
        p.drain    = drain;
        p.may_idle = may_idle;
        cmd_q      = {cmd_q, p};
    endtask

    // ------------------------------------------------------------------------
    // driver: presents the next pending transaction, holds it while busy,
    // and drops start for random idle bursts between transactions
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left <= 0;
        end
        else if (!start || !busy)
        begin
            if (idle_left != 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (cmd_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (cmd_q[0].drain && (start || taken_cnt != answered_cnt))
            begin
                // still a transaction in flight, wait for the table to go quiet
                start <= 1'b0;
            end
            else if (cmd_q[0].may_idle && $urandom_range(0, 7) == 0)
            begin
                start     <= 1'b0;
                idle_left <= $urandom_range(0, 5);
            end
            else
            begin
                drv_item = cmd_q.pop_front();
                req   <= drv_item.req;
                start <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks the response shown this cycle first, then predicts the
    // transaction accepted at this edge, so the order of expectations is fixed
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                answered_cnt <= answered_cnt + 1;
                if (due_rsp_q.size() == 0)
                begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_REPORTS)
                        $display("%0d: response with no transaction pending: %h",
                                 cycle_cnt, rsp);
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.status !== want.status ||
                        rsp.out_src_ip !== want.out_src_ip ||
                        rsp.out_src_port !== want.out_src_port ||
                        rsp.out_dst_ip !== want.out_dst_ip ||
                        rsp.out_dst_port !== want.out_dst_port)
                    begin
                        bad_cnt++;
                        if (bad_cnt <= MAX_REPORTS)
                        begin
                            $write("%0d: mismatch status %0d/%0d src %h:%h/%h:%h ",
                                   cycle_cnt, want.status, rsp.status,
                                   want.out_src_ip, want.out_src_port,
                                   rsp.out_src_ip, rsp.out_src_port);
                            $display("dst %h:%h/%h:%h (expected/actual)",
                                     want.out_dst_ip, want.out_dst_port,
                                     rsp.out_dst_ip, rsp.out_dst_port);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                due_rsp_q = {due_rsp_q, rule_table_response(req)};
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    // run limit: a hang or a lost response ends here
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("nat_rule_table regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int                k;
        int                seg;
        logic [31:0]       ip_a;
        logic [31:0]       ip_b;
        logic [31:0]       ip_c;
        logic [31:0]       ip_d;
        nrt_pkg::nrt_req_t r;

        ip_pool[0]   = '0;
        ip_pool[1]   = '1;
        port_pool[0] = '0;
        port_pool[1] = '1;
        for (k = 2; k < 8; k++)
        begin
            ip_pool[k]   = $urandom;
            port_pool[k] = 16'($urandom);
        end
        ip_a = $urandom;
        ip_b = $urandom;
        ip_c = $urandom;
        ip_d = $urandom;

        // directed: empty table, unused command, wildcards, keep-old values,
        // first match wins, near-miss remove, remove regardless of kind
        queue_item(apply_req('1, '1, '0, '0), 1'b0, 1'b1);
        queue_item(remove_req('0, '0), 1'b0, 1'b1);
        r     = '1;
        r.cmd = CMD_UNUSED;
        queue_item(r, 1'b0, 1'b1);
        queue_item(add_req(nrt_pkg::KIND_SNAT, ip_a, 16'd1000, '0, 16'd2000), 1'b0, 1'b1);
        queue_item(add_req(KIND_DNAT, '0, 16'd80, '1, '0), 1'b0, 1'b1);
        queue_item(apply_req(ip_a, 16'd1000, ip_b, 16'd443), 1'b0, 1'b1);
        queue_item(apply_req(ip_c, 16'd5, ip_d, 16'd80), 1'b0, 1'b1);
        queue_item(apply_req(ip_a, 16'd1000, ip_d, 16'd80), 1'b0, 1'b1);
        queue_item(apply_req(ip_a, 16'd999, ip_d, 16'd81), 1'b0, 1'b1);
        queue_item(remove_req(ip_a, 16'd999), 1'b0, 1'b1);
        r           = remove_req('0, 16'd80);
        r.rule_kind = nrt_pkg::KIND_SNAT;
        queue_item(r, 1'b0, 1'b1);
        queue_item(apply_req(ip_c, 16'd5, ip_d, 16'd80), 1'b0, 1'b1);
        queue_item(add_req(KIND_DNAT, '1, '1, '1, '1), 1'b0, 1'b1);
        queue_item(apply_req(ip_c, 16'd5, '1, '1), 1'b0, 1'b1);
        queue_item(add_req(nrt_pkg::KIND_SNAT, '0, '0, '0, '0), 1'b0, 1'b1);
        queue_item(apply_req('1, '1, '1, '1), 1'b0, 1'b1);
        used_pairs = {used_pairs, {ip_a, 16'd1000}};
        used_pairs = {used_pairs, {ip_d, 16'd80}};

        // random: mixes alternate between filling and draining the table,
        // idle bursts in most segments, none in the tail
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            seg = k / SEG_LEN;
            if (k < 16)
                r = random_req(100, 0);
            else if (seg % 2 == 0)
                r = random_req(50, 15);
            else
                r = random_req(20, 45);
            queue_item(r, (k == 0 || k == 250 || k == 430),
                       (k < RAND_ITEMS - CALM_TAIL) && (seg % 3 != 2));
        end
        total_items = cmd_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // every transaction taken and answered, then let the block go quiet
        while (taken_cnt != total_items || answered_cnt != taken_cnt)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        // a response still owed counts as a failure
        if (bad_cnt == 0 && due_rsp_q.size() == 0)
            $display("nat_rule_table regression: pass");
        else
            $display("nat_rule_table regression: fail");
        $finish;
    end

endmodule
